/* rtl/core/frsm_pkg.sv */
// Shared types and constants for the fan response stall monitor.
package frsm_pkg;

    localparam int RPM_W    = 20;
    localparam int REQ_W    = 21;
    localparam int TIME_W   = 40;
    localparam int GEND_W   = 41;
    localparam int FCNT_W   = 8;
    localparam int FIDX_W   = 6;
    localparam int STAT_W   = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W = 128;
    localparam int M_DATA_W = 32;

    // Field offsets inside the input tdata.
    localparam int IN_FAN_LSB  = 0;
    localparam int IN_TGT_LSB  = 6;
    localparam int IN_MIN_LSB  = 26;
    localparam int IN_ACT_LSB  = 46;
    localparam int IN_REP_LSB  = 66;
    localparam int IN_NOW_LSB  = 86;

    // Table entry: expected target, grace end and failure count.
    localparam int ENTRY_W = RPM_W + GEND_W + FCNT_W;

    localparam logic [STAT_W-1:0] STAT_OK             = 3'd0;
    localparam logic [STAT_W-1:0] STAT_INVALID        = 3'd1;
    localparam logic [STAT_W-1:0] STAT_TARGET_CHANGED = 3'd2;
    localparam logic [STAT_W-1:0] STAT_GRACE          = 3'd3;
    localparam logic [STAT_W-1:0] STAT_STALLED        = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_GRACE_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAIL_LIMIT   = 2'd2;

    localparam logic [15:0] GRACE_PERIOD_RST = 16'd5000;
    localparam logic [15:0] TOLERANCE_RST    = 16'd800;
    localparam logic [7:0]  FAIL_LIMIT_RST   = 8'd3;

    localparam logic KIND_NOTE    = 1'b0;
    localparam logic KIND_OBSERVE = 1'b1;

    typedef enum logic [0:0] {
        S_IDLE,
        S_CALC
    } state_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } ctl_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

/* rtl/core/fan_response_stall_monitor_core.sv */
// Flow: the input transfer captures the item and reads the fan table; the item is then
// evaluated, and it commits to the result register once that register is free.
// A new item is accepted only after the last one has committed: the registered table read
// comes ahead of the evaluate-and-write step, which waits while the result register is full.
// Reset (aresetn low, synchronous) disarms all fans, empties the result
// register and restores the configuration registers to their defaults.
module fan_response_stall_monitor_core import frsm_pkg::*; #(
    parameter int NUM_FANS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // tdata: fan, new target, fan minimum, measured speed,
    // reported target, time in ms, zero fill
    input  logic [S_DATA_W-1:0]   s_tdata,
    // tuser: kind
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // tdata: status, required_valid, required speed, zero fill
    output logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    ctl_cmd_t   ctl_cmd;
    dp_status_t dp_status;

    frsm_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .dp_status (dp_status),
        .ctl_cmd   (ctl_cmd)
    );

    frsm_datapath #(
        .NUM_FANS(NUM_FANS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl_cmd   (ctl_cmd),
        .dp_status (dp_status),
        .in_kind   (s_tuser),
        .in_data   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

/* rtl/core/frsm_ram.sv */
// Generic single-port-write, registered-read RAM.
module frsm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                    aclk,
    input  logic                                    wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/frsm_ctrl.sv */
// Controller state machine: sequences capture, table read and commit.
module frsm_ctrl import frsm_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t dp_status,
    output ctl_cmd_t   ctl_cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_CALC;
                end
            end
            S_CALC: begin
                if (dp_status.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_tready        = 1'b0;
        ctl_cmd.capture = 1'b0;
        ctl_cmd.commit  = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready        = 1'b1;
                ctl_cmd.capture = s_tvalid;
            end
            S_CALC: begin
                ctl_cmd.commit = dp_status.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/core/frsm_datapath.sv */
// Datapath: item registers, fan table, checks and result register.
module frsm_datapath import frsm_pkg::*; #(
    parameter int NUM_FANS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ctl_cmd_t              ctl_cmd,
    output dp_status_t            dp_status,
    input  logic                  in_kind,
    input  logic [S_DATA_W-1:0]   in_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [M_DATA_W-1:0]   out_data
);

    localparam int IDX_W = (NUM_FANS > 1) ? $clog2(NUM_FANS) : 1;
    localparam logic [FIDX_W:0] NUM_FANS_C = (FIDX_W + 1)'(NUM_FANS);

    // Configuration registers.
    logic [15:0] grace_period_reg;
    logic [15:0] tolerance_reg;
    logic [7:0]  fail_limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grace_period_reg <= GRACE_PERIOD_RST;
            tolerance_reg    <= TOLERANCE_RST;
            fail_limit_reg   <= FAIL_LIMIT_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_GRACE_PERIOD: grace_period_reg <= cfg_wdata;
                CFG_TOLERANCE:    tolerance_reg    <= cfg_wdata;
                CFG_FAIL_LIMIT:   fail_limit_reg   <= cfg_wdata[7:0];
                default:          ;
            endcase
        end
    end

    // Item registers.
    logic              kind_reg;
    logic [FIDX_W-1:0] fan_reg;
    logic [RPM_W-1:0]  target_reg;
    logic [RPM_W-1:0]  minimum_reg;
    logic [RPM_W-1:0]  actual_reg;
    logic [RPM_W-1:0]  reported_reg;
    logic [TIME_W-1:0] now_reg;

    always_ff @(posedge aclk) begin
        if (ctl_cmd.capture) begin
            kind_reg     <= in_kind;
            fan_reg      <= in_data[IN_FAN_LSB +: FIDX_W];
            target_reg   <= in_data[IN_TGT_LSB +: RPM_W];
            minimum_reg  <= in_data[IN_MIN_LSB +: RPM_W];
            actual_reg   <= in_data[IN_ACT_LSB +: RPM_W];
            reported_reg <= in_data[IN_REP_LSB +: RPM_W];
            now_reg      <= in_data[IN_NOW_LSB +: TIME_W];
        end
    end

    // Fan table: armed bits in flops, the rest in RAM.
    logic [NUM_FANS-1:0] armed_reg;
    logic [ENTRY_W-1:0]  entry_rd;
    logic [ENTRY_W-1:0]  entry_wr;
    logic                entry_we;
    logic [IDX_W-1:0]    rd_idx;
    logic [IDX_W-1:0]    fan_idx;

    assign rd_idx  = in_data[IN_FAN_LSB +: IDX_W];
    assign fan_idx = fan_reg[IDX_W-1:0];

    frsm_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(NUM_FANS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (entry_we),
        .wr_addr (fan_idx),
        .wr_data (entry_wr),
        .rd_en   (ctl_cmd.capture),
        .rd_addr (rd_idx),
        .rd_data (entry_rd)
    );

    logic [RPM_W-1:0]  exp_tgt;
    logic [GEND_W-1:0] grace_end;
    logic [FCNT_W-1:0] fail_cnt;

    assign exp_tgt   = entry_rd[GEND_W + FCNT_W +: RPM_W];
    assign grace_end = entry_rd[FCNT_W +: GEND_W];
    assign fail_cnt  = entry_rd[FCNT_W-1:0];

    // Evaluation of the captured item.
    logic              fan_ok;
    logic              armed;
    logic [RPM_W-1:0]  tgt_diff;
    logic [RPM_W-1:0]  span;
    logic [REQ_W-1:0]  required;
    logic [REQ_W:0]    reach;
    logic [FCNT_W-1:0] fail_inc;
    logic [STAT_W-1:0] res_status;
    logic              res_valid;
    logic [REQ_W-1:0]  res_rpm;
    logic              arm_set;
    logic [RPM_W-1:0]  new_tgt;
    logic [GEND_W-1:0] new_gend;
    logic [FCNT_W-1:0] new_fcnt;

    assign fan_ok = {1'b0, fan_reg} < NUM_FANS_C;
    assign armed  = fan_ok && armed_reg[fan_idx];

    assign tgt_diff = (reported_reg > exp_tgt) ? (reported_reg - exp_tgt)
                                               : (exp_tgt - reported_reg);
    assign span     = (exp_tgt > minimum_reg) ? (exp_tgt - minimum_reg) : '0;
    assign required = (span <= {4'b0, tolerance_reg})
                    ? {1'b0, minimum_reg}
                    : ({1'b0, minimum_reg} + {1'b0, exp_tgt});
    // Twice the sum of measured speed and tolerance, in 1/32 rpm.
    assign reach    = {({1'b0, actual_reg} + {5'b0, tolerance_reg}), 1'b0};
    assign fail_inc = (fail_cnt == '1) ? fail_cnt : (fail_cnt + 1'b1);

    always_comb begin
        res_status = STAT_OK;
        res_valid  = 1'b0;
        res_rpm    = '0;
        entry_we   = 1'b0;
        arm_set    = 1'b0;
        new_tgt    = exp_tgt;
        new_gend   = grace_end;
        new_fcnt   = fail_cnt;
        if (!fan_ok) begin
            res_status = STAT_INVALID;
        end else if (kind_reg == KIND_NOTE) begin
            if (target_reg == '0) begin
                res_status = STAT_INVALID;
            end else begin
                entry_we = ctl_cmd.commit;
                new_tgt  = target_reg;
                if (!armed) begin
                    arm_set  = ctl_cmd.commit;
                    new_gend = {1'b0, now_reg} + {25'b0, grace_period_reg};
                    new_fcnt = '0;
                end else if (target_reg <= exp_tgt) begin
                    new_fcnt = '0;
                end
            end
        end else if (!armed || minimum_reg == '0 || reported_reg == '0) begin
            res_status = STAT_INVALID;
        end else if (tgt_diff > {4'b0, tolerance_reg}) begin
            res_status = STAT_TARGET_CHANGED;
        end else if ({1'b0, now_reg} < grace_end) begin
            res_status = STAT_GRACE;
        end else begin
            res_valid = 1'b1;
            res_rpm   = required;
            entry_we  = ctl_cmd.commit;
            if (reach >= {1'b0, required}) begin
                new_fcnt = '0;
            end else begin
                new_fcnt = fail_inc;
                if (fail_inc >= fail_limit_reg) begin
                    res_status = STAT_STALLED;
                end
            end
        end
    end

    assign entry_wr = {new_tgt, new_gend, new_fcnt};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg <= '0;
        end else if (arm_set) begin
            armed_reg[fan_idx] <= 1'b1;
        end
    end

    // Result register; a finished result waits here for its transfer.
    logic              out_valid_reg;
    logic [STAT_W-1:0] status_reg;
    logic              req_valid_reg;
    logic [REQ_W-1:0]  req_rpm_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (ctl_cmd.commit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl_cmd.commit) begin
            status_reg    <= res_status;
            req_valid_reg <= res_valid;
            req_rpm_reg   <= res_rpm;
        end
    end

    assign dp_status.out_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = {7'b0, req_rpm_reg, req_valid_reg, status_reg};

endmodule

/* tb/fan_response_stall_monitor_core_tb.sv */
// Self-checking testbench for the fan response stall monitor core.
`timescale 1ns / 100ps

module fan_response_stall_monitor_core_tb import frsm_pkg::*;;

    localparam int FAN_COUNT      = 8;
    localparam int STUCK_LIMIT    = 3000;
    localparam int DRAIN_CYCLES   = 6;
    localparam int PHASE_COUNT    = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic                kind;
        logic [FIDX_W-1:0]   fan;
        logic [RPM_W-1:0]    target;
        logic [RPM_W-1:0]    minimum;
        logic [RPM_W-1:0]    actual;
        logic [RPM_W-1:0]    reported;
        logic [TIME_W-1:0]   now_ms;
    } fan_item_t;

    typedef struct packed {
        logic [STAT_W-1:0]   status;
        logic                req_valid;
        logic [REQ_W-1:0]    req_rpm;
    } fan_result_t;

    typedef struct packed {
        fan_item_t   item;
        logic        typed;
        fan_result_t want;
    } dir_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // Predictor copy of the fan table and the configuration.
    bit                    fan_armed_q    [FAN_COUNT];
    bit [RPM_W-1:0]        fan_target_q   [FAN_COUNT];
    bit [GEND_W-1:0]       fan_grace_end_q[FAN_COUNT];
    bit [FCNT_W-1:0]       fan_fail_q     [FAN_COUNT];
    bit [15:0]             grace_cfg;
    bit [15:0]             tol_cfg;
    bit [7:0]              limit_cfg;

    fan_result_t           pending_results[$];
    int                    mismatch_count;
    int                    stuck_cycles = 0;
    bit                    quiet_phase;
    bit [TIME_W-1:0]       clock_ms;

    dir_row_t directed_rows [22] = '{
        // Observe before any target is known.
        '{'{KIND_OBSERVE, 6'd0, 20'd0, 20'd8000, 20'd0, 20'd16000, 40'd0},
          1'b1, '{STAT_INVALID, 1'b0, 21'd0}},
        '{'{KIND_NOTE, 6'd63, 20'hFFFFF, 20'd0, 20'd0, 20'd0, 40'd0},
          1'b1, '{STAT_INVALID, 1'b0, 21'd0}},
        '{'{KIND_NOTE, 6'd0, 20'd0, 20'd0, 20'd0, 20'd0, 40'd0},
          1'b1, '{STAT_INVALID, 1'b0, 21'd0}},
        '{'{KIND_NOTE, 6'd0, 20'd16000, 20'd0, 20'd0, 20'd0, 40'd0},
          1'b1, '{STAT_OK, 1'b0, 21'd0}},
        '{'{KIND_OBSERVE, 6'd0, 20'd0, 20'd8000, 20'd0, 20'd16000, 40'd100},
          1'b1, '{STAT_GRACE, 1'b0, 21'd0}},
        '{'{KIND_OBSERVE, 6'd0, 20'd0, 20'd8000, 20'd0, 20'd20000, 40'd100},
          1'b1, '{STAT_TARGET_CHANGED, 1'b0, 21'd0}},
        '{'{KIND_OBSERVE, 6'd0, 20'd0, 20'd0, 20'd0, 20'd16000, 40'd6000},
          1'b1, '{STAT_INVALID, 1'b0, 21'd0}},
        '{'{KIND_OBSERVE, 6'd0, 20'd0, 20'd8000, 20'd0, 20'd0, 40'd6000},
          1'b1, '{STAT_INVALID, 1'b0, 21'd0}},
        // Grace just over; then repeated shortfalls until a stall.
        '{'{KIND_OBSERVE, 6'd0, 20'd0, 20'd8000, 20'd12000, 20'd16000, 40'd5000},
          1'b0, '0},
        '{'{KIND_OBSERVE, 6'd0, 20'd0, 20'd8000, 20'd0, 20'd16000, 40'd5001},
          1'b0, '0},
        '{'{KIND_OBSERVE, 6'd0, 20'd0, 20'd8000, 20'd0, 20'd16000, 40'd5002},
          1'b0, '0},
        '{'{KIND_OBSERVE, 6'd0, 20'd0, 20'd8000, 20'd0, 20'd16000, 40'd5003},
          1'b0, '0},
        '{'{KIND_NOTE, 6'd0, 20'd16000, 20'd0, 20'd0, 20'd0, 40'd5004},
          1'b0, '0},
        '{'{KIND_OBSERVE, 6'd0, 20'd0, 20'd8000, 20'd0, 20'd16000, 40'd5005},
          1'b0, '0},
        // Latest possible time: the grace end needs the 41st bit.
        '{'{KIND_NOTE, 6'd1, 20'hFFFFF, 20'd0, 20'd0, 20'd0, 40'hFF_FFFF_FFFF},
          1'b1, '{STAT_OK, 1'b0, 21'd0}},
        '{'{KIND_OBSERVE, 6'd1, 20'd0, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF,
            40'hFF_FFFF_FFFF},
          1'b1, '{STAT_GRACE, 1'b0, 21'd0}},
        '{'{KIND_NOTE, 6'd7, 20'd1000, 20'd0, 20'd0, 20'd0, 40'd0},
          1'b1, '{STAT_OK, 1'b0, 21'd0}},
        '{'{KIND_OBSERVE, 6'd7, 20'd0, 20'hFFFFF, 20'hFFFFF, 20'd1000, 40'd10000},
          1'b1, '{STAT_OK, 1'b1, 21'h0FFFFF}},
        '{'{KIND_NOTE, 6'd8, 20'd500, 20'd0, 20'd0, 20'd0, 40'd10000},
          1'b1, '{STAT_INVALID, 1'b0, 21'd0}},
        '{'{KIND_OBSERVE, 6'd63, 20'd0, 20'd1000, 20'd0, 20'd1000, 40'd10000},
          1'b1, '{STAT_INVALID, 1'b0, 21'd0}},
        '{'{KIND_NOTE, 6'd7, 20'd1800, 20'd0, 20'd0, 20'd0, 40'd10001},
          1'b0, '0},
        '{'{KIND_OBSERVE, 6'd7, 20'd0, 20'd1000, 20'd0, 20'd1800, 40'd10001},
          1'b0, '0}
    };

    fan_response_stall_monitor_core #(
        .NUM_FANS(FAN_COUNT)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Works out the result of one item and updates the table copy.
    function automatic fan_result_t predict_fan_result(fan_item_t it);
        fan_result_t     r;
        int              fi;
        bit [RPM_W-1:0]  exp_t;
        bit [RPM_W-1:0]  diff;
        bit [RPM_W-1:0]  span;
        bit [REQ_W-1:0]  need;
        bit [22:0]       reach;
        r = '{STAT_INVALID, 1'b0, '0};
        if (it.fan >= FAN_COUNT)
            return r;
        fi = it.fan;
        if (it.kind == KIND_NOTE) begin
            if (it.target == '0)
                return r;
            if (!fan_armed_q[fi]) begin
                fan_grace_end_q[fi] = {1'b0, it.now_ms} + GEND_W'(grace_cfg);
                fan_fail_q[fi] = '0;
                fan_armed_q[fi] = 1'b1;
            end else if (it.target <= fan_target_q[fi]) begin
                fan_fail_q[fi] = '0;
            end
            fan_target_q[fi] = it.target;
            r.status = STAT_OK;
            return r;
        end
        if (!fan_armed_q[fi] || it.minimum == '0 || it.reported == '0)
            return r;
        exp_t = fan_target_q[fi];
        diff = (it.reported > exp_t) ? it.reported - exp_t : exp_t - it.reported;
        if (diff > RPM_W'(tol_cfg)) begin
            r.status = STAT_TARGET_CHANGED;
            return r;
        end
        if ({1'b0, it.now_ms} < fan_grace_end_q[fi]) begin
            r.status = STAT_GRACE;
            return r;
        end
        span = (exp_t > it.minimum) ? exp_t - it.minimum : '0;
        if (span <= RPM_W'(tol_cfg))
            need = REQ_W'(it.minimum);
        else
            need = REQ_W'(it.minimum) + REQ_W'(exp_t);
        r.req_valid = 1'b1;
        r.req_rpm = need;
        r.status = STAT_OK;
        reach = (23'(it.actual) + 23'(tol_cfg)) << 1;
        if (reach >= 23'(need)) begin
            fan_fail_q[fi] = '0;
        end else begin
            if (fan_fail_q[fi] < 8'd255)
                fan_fail_q[fi] = fan_fail_q[fi] + 8'd1;
            if (fan_fail_q[fi] >= limit_cfg)
                r.status = STAT_STALLED;
        end
        return r;
    endfunction

    // Random gap length: mostly none or short, now and then long; none in the quiet phase.
    function automatic int idle_len();
        int unsigned pick;
        pick = $urandom_range(99);
        if (quiet_phase || pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Mostly well-formed traffic against the current table, some noise.
    function automatic fan_item_t random_fan_item();
        fan_item_t       it;
        int unsigned     mix;
        int unsigned     pick;
        int              fi;
        int              guess;
        bit [RPM_W-1:0]  exp_t;
        bit [RPM_W-1:0]  offs;
        bit [RPM_W-1:0]  span;
        bit [REQ_W-1:0]  need;
        it = '0;
        pick = $urandom_range(99);
        if (pick < 70)
            clock_ms = clock_ms + TIME_W'($urandom_range(0, 50));
        else if (pick < 95)
            clock_ms = clock_ms + TIME_W'($urandom_range(0, 3000));
        else
            clock_ms = clock_ms + TIME_W'($urandom_range(0, 70000));
        it.now_ms = clock_ms;
        it.fan = FIDX_W'($urandom_range(0, FAN_COUNT - 1));
        if ($urandom_range(19) == 0)
            it.fan = FIDX_W'($urandom_range(FAN_COUNT, 63));
        fi = (it.fan < FAN_COUNT) ? int'(it.fan) : 0;
        mix = $urandom_range(99);
        if (mix < 10) begin
            it.kind = 1'($urandom);
            it.fan = FIDX_W'($urandom);
            it.target = RPM_W'($urandom);
            it.minimum = RPM_W'($urandom);
            it.actual = RPM_W'($urandom);
            it.reported = RPM_W'($urandom);
            it.now_ms = {8'($urandom), 32'($urandom)};
            // A first target at a far time would hold its fan in grace for good.
            if (it.kind == KIND_NOTE && it.fan < FAN_COUNT && !fan_armed_q[it.fan])
                it.now_ms = clock_ms;
        end else if (mix < 40) begin
            it.kind = KIND_NOTE;
            pick = $urandom_range(99);
            if (pick < 30 && fan_armed_q[fi])
                it.target = fan_target_q[fi] - RPM_W'($urandom_range(0, fan_target_q[fi]));
            else if (pick < 34)
                it.target = '0;
            else
                it.target = RPM_W'($urandom_range(1, 20'hFFFFF));
        end else begin
            it.kind = KIND_OBSERVE;
            exp_t = fan_armed_q[fi] ? fan_target_q[fi] : RPM_W'($urandom);
            offs = RPM_W'($urandom_range(0, tol_cfg));
            if ($urandom_range(9) == 0)
                offs = offs + RPM_W'($urandom_range(1, 4000));
            it.reported = $urandom_range(1) ? exp_t + offs : exp_t - offs;
            if ($urandom_range(49) == 0)
                it.reported = '0;
            pick = $urandom_range(99);
            if (pick < 50)
                it.minimum = exp_t - RPM_W'($urandom_range(0, exp_t));
            else if (pick < 75)
                it.minimum = exp_t - RPM_W'(tol_cfg) - 20'd1 + RPM_W'($urandom_range(0, 2));
            else
                it.minimum = RPM_W'($urandom);
            if (it.minimum == '0 && $urandom_range(19) != 0)
                it.minimum = 20'd1;
            span = (exp_t > it.minimum) ? exp_t - it.minimum : '0;
            need = (span > RPM_W'(tol_cfg)) ? REQ_W'(it.minimum) + REQ_W'(exp_t)
                                            : REQ_W'(it.minimum);
            // Aim at the shortfall threshold so both outcomes occur.
            guess = int'(need >> 1) - int'(tol_cfg) + int'($urandom_range(0, 8)) - 4;
            if (guess < 0)
                guess = 0;
            if (guess > 20'hFFFFF)
                guess = 20'hFFFFF;
            it.actual = RPM_W'(guess);
            if ($urandom_range(4) == 0)
                it.actual = RPM_W'($urandom);
        end
        return it;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // Offers one item, waits for its transfer and records the expected result.
    task automatic send_item(input fan_item_t it, input bit typed, input fan_result_t want);
        int          gap;
        fan_result_t calc;
        gap = idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.kind;
        s_tdata <= {2'b00, it.now_ms, it.reported, it.actual, it.minimum,
                    it.target, it.fan};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        calc = predict_fan_result(it);
        pending_results.push_back(typed ? want : calc);
    endtask

    task automatic set_config(input bit [15:0] grace, input bit [15:0] tol,
                              input bit [7:0] limit);
        cfg_we <= 1'b1;
        cfg_addr <= CFG_GRACE_PERIOD;
        cfg_wdata <= grace;
        @(posedge aclk);
        grace_cfg = grace;
        cfg_addr <= CFG_TOLERANCE;
        cfg_wdata <= tol;
        @(posedge aclk);
        tol_cfg = tol;
        // The upper byte is outside the register and must be dropped.
        cfg_addr <= CFG_FAIL_LIMIT;
        cfg_wdata <= {8'($urandom), limit};
        @(posedge aclk);
        limit_cfg = limit;
        cfg_addr <= CFG_SPARE;
        cfg_wdata <= 16'($urandom);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int ph;
        int n;
        int count;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= 1'b0;
        cfg_we <= 1'b0;
        cfg_addr <= '0;
        cfg_wdata <= '0;
        aresetn <= 1'b0;
        mismatch_count = 0;
        quiet_phase = 1'b0;
        grace_cfg = GRACE_PERIOD_RST;
        tol_cfg = TOLERANCE_RST;
        limit_cfg = FAIL_LIMIT_RST;
        for (int i = 0; i < FAN_COUNT; i++) begin
            fan_armed_q[i] = 1'b0;
            fan_target_q[i] = '0;
            fan_grace_end_q[i] = '0;
            fan_fail_q[i] = '0;
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
        s_tvalid <= 1'b0;
        clock_ms = 40'd10001;

        for (ph = 0; ph < PHASE_COUNT; ph++) begin
            wait_drained();
            quiet_phase = (ph == 2);
            count = 90;
            case (ph)
                0: set_config(16'd0, 16'd0, 8'd1);
                1: set_config(16'hFFFF, 16'hFFFF, 8'd255);
                2: set_config(16'($urandom_range(0, 3000)), 16'($urandom_range(0, 4000)),
                              8'($urandom_range(2, 8)));
                // A limit of zero is outside the range: every shortfall stalls.
                3: set_config(16'd100, 16'd800, 8'd0);
                4: begin
                    set_config(GRACE_PERIOD_RST, TOLERANCE_RST, FAIL_LIMIT_RST);
                    clock_ms = 40'hFF_FF00_0000;
                    count = 100;
                end
                default: begin
                    set_config(16'($urandom), 16'($urandom), 8'($urandom_range(1, 255)));
                    count = 100;
                end
            endcase
            for (n = 0; n < count; n++)
                send_item(random_fan_item(), 1'b0, '0);
            s_tvalid <= 1'b0;
        end
        quiet_phase = 1'b0;
        wait_drained();

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        int run;
        int stall;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            run = $urandom_range(1, 12);
            m_tready <= 1'b1;
            repeat (run) @(posedge aclk);
            stall = idle_len();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    // Result checker: every transfer is matched with the oldest expectation.
    always @(posedge aclk) begin
        fan_result_t seen;
        fan_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            seen.status = m_tdata[2:0];
            seen.req_valid = m_tdata[3];
            seen.req_rpm = m_tdata[24:4];
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected, tdata %h", m_tdata));
            end else begin
                want = pending_results.pop_front();
                if (seen.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              seen.status, want.status));
                if (seen.req_valid !== want.req_valid)
                    report_mismatch($sformatf("required_valid %0b, expected %0b",
                                              seen.req_valid, want.req_valid));
                if (seen.req_rpm !== want.req_rpm)
                    report_mismatch($sformatf("required speed %0d, expected %0d",
                                              seen.req_rpm, want.req_rpm));
            end
        end
    end

    // Ends the run when no transfer happens on either side for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles == STUCK_LIMIT) begin
            $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
                     $time, STUCK_LIMIT, pending_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
